// ===== hw/rtl/tbecu_pkg.sv =====
`timescale 1ns / 1ps

package tbecu_pkg;

  localparam int KNOTS      = 9;
  localparam int LEVELS     = 15;
  localparam int KNOT_IW    = 4;
  localparam int SPEED_W    = 7;
  localparam int DIST_W     = 24;
  localparam int IDX_W      = 4;
  localparam int VEL_W      = 7;
  localparam int UM_W       = 21;
  localparam int NUM_W      = 28;
  localparam int TICK_W     = 25;
  localparam int STOP_W     = 11;
  localparam int UNC_W      = 9;
  localparam int BRAKE_W    = 12;
  localparam int SET_NUM_W  = 16;
  localparam int SETTLE_W   = 10;
  localparam int WD_W       = 7;
  localparam int DIV_LANES  = 5;

  localparam int LANE_NOM   = 0;
  localparam int LANE_FAST  = 1;
  localparam int LANE_SLOW  = 2;
  localparam int LANE_MEAS  = 3;
  localparam int LANE_FLR   = 4;

  localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd120;
  localparam logic [SPEED_W-1:0] SPEED_SLOW = 7'd20;
  localparam logic [10:0]        IDX_BIAS   = 11'd60;
  localparam logic [10:0]        IDX_STEP   = 11'd120;
  localparam logic [IDX_W-1:0]   IDX_MAX    = 4'(LEVELS - 1);
  localparam logic [UM_W-1:0]    UM_ROUND   = 21'd999;
  localparam int                 MM_SHIFT   = 3;
  localparam int                 MUL_W      = 18;
  localparam logic [MUL_W-1:0]   MM_MUL     = 18'd134218;
  localparam int                 MM_PSHIFT  = 24;
  localparam int                 PROD_W     = 2 * MUL_W;
  localparam logic [UNC_W-1:0]   UNC_MIN    = 9'd250;
  localparam logic [SETTLE_W:0]  SETTLE_ADD = 11'd20;
  localparam logic [WD_W-1:0]    WD_SLOW    = 7'd100;
  localparam logic [WD_W-1:0]    WD_FAST    = 7'd60;

  typedef struct packed {
    logic               speed_valid;
    logic               slow;
    logic [IDX_W-1:0]   idx;
    logic [VEL_W-1:0]   v;
    logic [VEL_W-1:0]   vf;
    logic [VEL_W-1:0]   vs;
    logic [NUM_W-1:0]   dist_num;
    logic [NUM_W-1:0]   meas_num;
    logic [VEL_W-1:0]   meas_span;
    logic [UM_W-1:0]    meas_base;
    logic [NUM_W-1:0]   flr_num;
    logic [VEL_W-1:0]   flr_span;
    logic [UM_W-1:0]    flr_base;
  } item_t;

  typedef struct packed {
    logic               speed_valid;
    logic               slow;
    logic [IDX_W-1:0]   idx;
    logic [VEL_W-1:0]   v;
    logic [VEL_W-1:0]   vf;
    logic [VEL_W-1:0]   vs;
    logic [UM_W-1:0]    meas_base;
    logic [UM_W-1:0]    flr_base;
  } tag1_t;

  typedef struct packed {
    logic               speed_valid;
    logic               slow;
    logic [IDX_W-1:0]   idx;
    logic [VEL_W-1:0]   v;
    logic [VEL_W-1:0]   vf;
    logic [TICK_W-1:0]  nom_ticks;
    logic [TICK_W-1:0]  fast_ticks;
    logic [TICK_W-1:0]  slow_ticks;
    logic [STOP_W-1:0]  stop;
    logic [UNC_W-1:0]   unc;
    logic [BRAKE_W-1:0] brake;
  } tag2_t;

  function automatic logic [VEL_W-1:0] vel_lut(input logic [IDX_W-1:0] i);
    logic [VEL_W-1:0] r;
    case (i)
      4'd1:    r = 7'd12;
      4'd2:    r = 7'd18;
      4'd3:    r = 7'd24;
      4'd4:    r = 7'd31;
      4'd5:    r = 7'd38;
      4'd6:    r = 7'd45;
      4'd7:    r = 7'd52;
      4'd8:    r = 7'd59;
      4'd9:    r = 7'd66;
      4'd10:   r = 7'd73;
      4'd11:   r = 7'd80;
      4'd12:   r = 7'd87;
      4'd13:   r = 7'd94;
      4'd14:   r = 7'd101;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] vf_lut(input logic [IDX_W-1:0] i);
    logic [VEL_W-1:0] r;
    case (i)
      4'd1:    r = 7'd15;
      4'd2:    r = 7'd22;
      4'd3:    r = 7'd29;
      4'd4:    r = 7'd38;
      4'd5:    r = 7'd46;
      4'd6:    r = 7'd54;
      4'd7:    r = 7'd63;
      4'd8:    r = 7'd71;
      4'd9:    r = 7'd80;
      4'd10:   r = 7'd88;
      4'd11:   r = 7'd96;
      4'd12:   r = 7'd105;
      4'd13:   r = 7'd113;
      4'd14:   r = 7'd122;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] meas_knot(input logic [KNOT_IW-1:0] j);
    logic [VEL_W-1:0] r;
    case (j)
      4'd1:    r = 7'd20;
      4'd2:    r = 7'd40;
      4'd3:    r = 7'd60;
      4'd4:    r = 7'd70;
      4'd5:    r = 7'd80;
      4'd6:    r = 7'd90;
      4'd7:    r = 7'd100;
      4'd8:    r = 7'd120;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [UM_W-1:0] meas_val(input logic [KNOT_IW-1:0] j);
    logic [UM_W-1:0] r;
    case (j)
      4'd1:    r = 21'd50000;
      4'd2:    r = 21'd110000;
      4'd3:    r = 21'd240000;
      4'd4:    r = 21'd390000;
      4'd5:    r = 21'd530000;
      4'd6:    r = 21'd740000;
      4'd7:    r = 21'd875000;
      4'd8:    r = 21'd1435000;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] flr_knot(input logic [KNOT_IW-1:0] j);
    logic [VEL_W-1:0] r;
    case (j)
      4'd1:    r = 7'd14;
      4'd2:    r = 7'd20;
      4'd3:    r = 7'd30;
      4'd4:    r = 7'd40;
      4'd5:    r = 7'd60;
      4'd6:    r = 7'd80;
      4'd7:    r = 7'd100;
      4'd8:    r = 7'd120;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [UM_W-1:0] flr_val(input logic [KNOT_IW-1:0] j);
    logic [UM_W-1:0] r;
    case (j)
      4'd1:    r = 21'd38100;
      4'd2:    r = 21'd50800;
      4'd3:    r = 21'd63500;
      4'd4:    r = 21'd127000;
      4'd5:    r = 21'd342900;
      4'd6:    r = 21'd812800;
      4'd7:    r = 21'd1168400;
      4'd8:    r = 21'd1524000;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/tbecu_front.sv =====
`timescale 1ns / 1ps

module tbecu_front (
  input  logic [tbecu_pkg::SPEED_W-1:0] speed,
  input  logic [tbecu_pkg::DIST_W-1:0]  travel_mm,
  output tbecu_pkg::item_t              item
);

  logic                          in_range;
  logic [10:0]                   s14;
  logic [tbecu_pkg::IDX_W-1:0]   cnt;
  logic [tbecu_pkg::IDX_W-1:0]   idx;
  logic [tbecu_pkg::KNOT_IW-1:0] m_up, f_up, m_lo, f_lo;
  logic [tbecu_pkg::UM_W-1:0]    m_delta, f_delta;
  logic [tbecu_pkg::VEL_W-1:0]   m_off, f_off, v;
  tbecu_pkg::item_t              it;

  always_comb begin
    in_range = (speed != '0) && (speed <= tbecu_pkg::SPEED_MAX);
    s14 = ({4'b0, speed} << 4) - ({4'b0, speed} << 1) + tbecu_pkg::IDX_BIAS;
    cnt = '0;
    for (int k = 1; k < tbecu_pkg::LEVELS; k++) begin
      if (s14 >= 11'(k) * tbecu_pkg::IDX_STEP) cnt = cnt + 4'd1;
    end
    idx = (cnt == '0) ? 4'd1 : ((cnt > tbecu_pkg::IDX_MAX) ? tbecu_pkg::IDX_MAX : cnt);
    v = tbecu_pkg::vel_lut(idx);

    m_up = 4'(tbecu_pkg::KNOTS - 1);
    f_up = 4'(tbecu_pkg::KNOTS - 1);
    for (int j = tbecu_pkg::KNOTS - 2; j >= 1; j--) begin
      if (speed <= tbecu_pkg::meas_knot(4'(j))) m_up = 4'(j);
      if (speed <= tbecu_pkg::flr_knot(4'(j))) f_up = 4'(j);
    end
    m_lo = m_up - 4'd1;
    f_lo = f_up - 4'd1;
    m_off = speed - tbecu_pkg::meas_knot(m_lo);
    f_off = speed - tbecu_pkg::flr_knot(f_lo);
    m_delta = tbecu_pkg::meas_val(m_up) - tbecu_pkg::meas_val(m_lo);
    f_delta = tbecu_pkg::flr_val(f_up) - tbecu_pkg::flr_val(f_lo);

    it.speed_valid = 1'b1;
    it.slow        = (speed <= tbecu_pkg::SPEED_SLOW);
    it.idx         = idx;
    it.v           = v;
    it.vf          = tbecu_pkg::vf_lut(idx);
    it.vs          = (v[tbecu_pkg::VEL_W-1:1] == '0) ? 7'd1 : {1'b0, v[tbecu_pkg::VEL_W-1:1]};
    it.dist_num    = ({4'b0, travel_mm} << 3) + ({4'b0, travel_mm} << 1);
    it.meas_num    = {7'b0, m_delta} * {21'b0, m_off};
    it.meas_span   = tbecu_pkg::meas_knot(m_up) - tbecu_pkg::meas_knot(m_lo);
    it.meas_base   = tbecu_pkg::meas_val(m_lo);
    it.flr_num     = {7'b0, f_delta} * {21'b0, f_off};
    it.flr_span    = tbecu_pkg::flr_knot(f_up) - tbecu_pkg::flr_knot(f_lo);
    it.flr_base    = tbecu_pkg::flr_val(f_lo);

    if (!in_range) begin
      it = '0;
      it.v = 7'd1;
      it.vf = 7'd1;
      it.vs = 7'd1;
      it.meas_span = 7'd1;
      it.flr_span = 7'd1;
    end
    item = it;
  end

endmodule

// ===== hw/rtl/tbecu_queue.sv =====
`timescale 1ns / 1ps

module tbecu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tbecu_pkg::item_t push_item,
  output logic             full,
  output logic             pop_vld,
  output tbecu_pkg::item_t pop_item
);

  tbecu_pkg::item_t ents_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  always_comb begin
    full = (cnt_r == 2'd2);
    pop = (cnt_r != 2'd0);
    pop_vld = pop;
    pop_item = ents_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ents_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/tbecu_div.sv =====
`timescale 1ns / 1ps

module tbecu_div #(
  parameter int NW    = 28,
  parameter int DW    = 7,
  parameter int LANES = 1,
  parameter int TW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [LANES-1:0][NW-1:0]     in_num,
  input  logic [LANES-1:0][DW-1:0]     in_den,
  input  logic [TW-1:0]                in_tag,
  output logic                         out_vld,
  output logic [LANES-1:0][NW-1:0]     out_quo,
  output logic [LANES-1:0]             out_nz,
  output logic [TW-1:0]                out_tag
);

  logic                     st_vld_r [NW];
  logic [LANES-1:0][NW-1:0] st_num_r [NW];
  logic [LANES-1:0][DW-1:0] st_den_r [NW];
  logic [LANES-1:0][DW-1:0] st_rem_r [NW];
  logic [LANES-1:0][NW-1:0] st_quo_r [NW];
  logic [TW-1:0]            st_tag_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic                     pv;
    logic [LANES-1:0][NW-1:0] pn, pq, quo_nxt;
    logic [LANES-1:0][DW-1:0] pd, pr, rem_nxt;
    logic [TW-1:0]            pt;
    logic [DW:0]              trial;

    if (s == 0) begin : g_in
      assign pv = in_vld;
      assign pn = in_num;
      assign pd = in_den;
      assign pr = '0;
      assign pq = '0;
      assign pt = in_tag;
    end else begin : g_prev
      assign pv = st_vld_r[s-1];
      assign pn = st_num_r[s-1];
      assign pd = st_den_r[s-1];
      assign pr = st_rem_r[s-1];
      assign pq = st_quo_r[s-1];
      assign pt = st_tag_r[s-1];
    end

    always_comb begin
      quo_nxt = pq;
      rem_nxt = pr;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        trial = {pr[l], pn[l][NW-1-s]};
        if (trial >= {1'b0, pd[l]}) begin
          rem_nxt[l] = DW'(trial - {1'b0, pd[l]});
          quo_nxt[l][NW-1-s] = 1'b1;
        end else begin
          rem_nxt[l] = trial[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[s] <= 1'b0;
      end else begin
        st_vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      st_num_r[s] <= pn;
      st_den_r[s] <= pd;
      st_rem_r[s] <= rem_nxt;
      st_quo_r[s] <= quo_nxt;
      st_tag_r[s] <= pt;
    end
  end

  always_comb begin
    out_vld = st_vld_r[NW-1];
    out_quo = st_quo_r[NW-1];
    out_tag = st_tag_r[NW-1];
    for (int l = 0; l < LANES; l++) begin
      out_nz[l] = (st_rem_r[NW-1][l] != '0);
    end
  end

endmodule

// ===== hw/rtl/tbecu_back.sv =====
`timescale 1ns / 1ps

module tbecu_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  tbecu_pkg::item_t               item,
  output logic                           out_strobe,
  output logic                           out_speed_valid,
  output logic [tbecu_pkg::IDX_W-1:0]    out_model_index,
  output logic [tbecu_pkg::VEL_W-1:0]    out_vel_dmm,
  output logic [tbecu_pkg::VEL_W-1:0]    out_fast_vel_dmm,
  output logic [tbecu_pkg::TICK_W-1:0]   out_nominal_ticks,
  output logic [tbecu_pkg::TICK_W-1:0]   out_fast_ticks,
  output logic [tbecu_pkg::TICK_W-1:0]   out_slow_ticks,
  output logic [tbecu_pkg::STOP_W-1:0]   out_stop_mm,
  output logic [tbecu_pkg::UNC_W-1:0]    out_uncertainty_mm,
  output logic [tbecu_pkg::BRAKE_W-1:0]  out_braking_mm,
  output logic [tbecu_pkg::SETTLE_W-1:0] out_settle_cnt,
  output logic [tbecu_pkg::WD_W-1:0]     out_watchdog_ticks
);

  localparam int NW = tbecu_pkg::NUM_W;
  localparam int DW = tbecu_pkg::VEL_W;
  localparam int L  = tbecu_pkg::DIV_LANES;
  localparam int T1 = $bits(tbecu_pkg::tag1_t);
  localparam int T2 = $bits(tbecu_pkg::tag2_t);
  localparam int SN = tbecu_pkg::SET_NUM_W;

  logic [L-1:0][NW-1:0] d1_num, d1_quo;
  logic [L-1:0][DW-1:0] d1_den;
  logic [L-1:0]         d1_nz;
  logic                 d1_vld;
  tbecu_pkg::tag1_t     t1_in, t1_out;

  always_comb begin
    d1_num[tbecu_pkg::LANE_NOM]  = item.dist_num;
    d1_num[tbecu_pkg::LANE_FAST] = item.dist_num;
    d1_num[tbecu_pkg::LANE_SLOW] = item.dist_num;
    d1_num[tbecu_pkg::LANE_MEAS] = item.meas_num;
    d1_num[tbecu_pkg::LANE_FLR]  = item.flr_num;
    d1_den[tbecu_pkg::LANE_NOM]  = item.v;
    d1_den[tbecu_pkg::LANE_FAST] = item.vf;
    d1_den[tbecu_pkg::LANE_SLOW] = item.vs;
    d1_den[tbecu_pkg::LANE_MEAS] = item.meas_span;
    d1_den[tbecu_pkg::LANE_FLR]  = item.flr_span;
    t1_in.speed_valid = item.speed_valid;
    t1_in.slow        = item.slow;
    t1_in.idx         = item.idx;
    t1_in.v           = item.v;
    t1_in.vf          = item.vf;
    t1_in.vs          = item.vs;
    t1_in.meas_base   = item.meas_base;
    t1_in.flr_base    = item.flr_base;
  end

  tbecu_div #(.NW(NW), .DW(DW), .LANES(L), .TW(T1)) u_div1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_num  (d1_num),
    .in_den  (d1_den),
    .in_tag  (t1_in),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_nz  (d1_nz),
    .out_tag (t1_out)
  );

  // stage a: finish ceilings, scale micrometres toward millimetres
  logic [NW-1:0]                 c_nom, c_fast, c_slow;
  logic [tbecu_pkg::UM_W-1:0]    m_um, f_um, m_y, f_y;
  logic [tbecu_pkg::MUL_W-1:0]   m_y8, f_y8;
  logic                          a_vld_r;
  tbecu_pkg::tag1_t              a_tag_r;
  logic [tbecu_pkg::TICK_W-1:0]  a_nom_r, a_fast_r, a_slow_r;
  logic [tbecu_pkg::PROD_W-1:0]  a_mprod_r, a_fprod_r;

  always_comb begin
    c_nom  = d1_quo[tbecu_pkg::LANE_NOM]  + NW'(d1_nz[tbecu_pkg::LANE_NOM]);
    c_fast = d1_quo[tbecu_pkg::LANE_FAST] + NW'(d1_nz[tbecu_pkg::LANE_FAST]);
    c_slow = d1_quo[tbecu_pkg::LANE_SLOW] + NW'(d1_nz[tbecu_pkg::LANE_SLOW]);
    m_um = t1_out.meas_base + d1_quo[tbecu_pkg::LANE_MEAS][tbecu_pkg::UM_W-1:0]
           + tbecu_pkg::UM_W'(d1_nz[tbecu_pkg::LANE_MEAS]);
    f_um = t1_out.flr_base + d1_quo[tbecu_pkg::LANE_FLR][tbecu_pkg::UM_W-1:0]
           + tbecu_pkg::UM_W'(d1_nz[tbecu_pkg::LANE_FLR]);
    m_y = m_um + tbecu_pkg::UM_ROUND;
    f_y = f_um + tbecu_pkg::UM_ROUND;
    m_y8 = m_y[tbecu_pkg::UM_W-1:tbecu_pkg::MM_SHIFT];
    f_y8 = f_y[tbecu_pkg::UM_W-1:tbecu_pkg::MM_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r   <= t1_out;
    a_nom_r   <= c_nom[tbecu_pkg::TICK_W-1:0];
    a_fast_r  <= c_fast[tbecu_pkg::TICK_W-1:0];
    a_slow_r  <= c_slow[tbecu_pkg::TICK_W-1:0];
    a_mprod_r <= m_y8 * tbecu_pkg::MM_MUL;
    a_fprod_r <= f_y8 * tbecu_pkg::MM_MUL;
  end

  // stage b: envelopes and settle numerator
  logic [tbecu_pkg::STOP_W-1:0]  stop, fstop;
  logic [tbecu_pkg::UNC_W-1:0]   unc, func;
  logic [tbecu_pkg::BRAKE_W-1:0] menv, fenv, brake;
  logic                          b_vld_r;
  tbecu_pkg::tag2_t              b_tag_r, t2_nxt, t2_out;
  logic [SN-1:0]                 b_num_r;
  logic [DW-1:0]                 b_vs_r;

  always_comb begin
    stop  = a_mprod_r[tbecu_pkg::MM_PSHIFT +: tbecu_pkg::STOP_W];
    fstop = a_fprod_r[tbecu_pkg::MM_PSHIFT +: tbecu_pkg::STOP_W];
    unc  = (stop[tbecu_pkg::STOP_W-1:2] > tbecu_pkg::UNC_MIN) ?
           stop[tbecu_pkg::STOP_W-1:2] : tbecu_pkg::UNC_MIN;
    func = (fstop[tbecu_pkg::STOP_W-1:2] > tbecu_pkg::UNC_MIN) ?
           fstop[tbecu_pkg::STOP_W-1:2] : tbecu_pkg::UNC_MIN;
    menv = {1'b0, stop} + {3'b0, unc};
    fenv = {1'b0, fstop} + {3'b0, func};
    brake = (menv > fenv) ? menv : fenv;
    t2_nxt.speed_valid = a_tag_r.speed_valid;
    t2_nxt.slow        = a_tag_r.slow;
    t2_nxt.idx         = a_tag_r.idx;
    t2_nxt.v           = a_tag_r.v;
    t2_nxt.vf          = a_tag_r.vf;
    t2_nxt.nom_ticks   = a_nom_r;
    t2_nxt.fast_ticks  = a_fast_r;
    t2_nxt.slow_ticks  = a_slow_r;
    t2_nxt.stop        = stop;
    t2_nxt.unc         = unc;
    t2_nxt.brake       = brake;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_tag_r <= t2_nxt;
    b_num_r <= ({4'b0, brake} << 3) + ({4'b0, brake} << 1);
    b_vs_r  <= a_tag_r.vs;
  end

  logic          d2_vld;
  logic [SN-1:0] d2_quo;
  logic          d2_nz;

  tbecu_div #(.NW(SN), .DW(DW), .LANES(1), .TW(T2)) u_div2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (b_vld_r),
    .in_num  (b_num_r),
    .in_den  (b_vs_r),
    .in_tag  (b_tag_r),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_nz  (d2_nz),
    .out_tag (t2_out)
  );

  // output register, zero every result field on a bad speed
  logic [SN-1:0] settle;
  logic          o_vld_r;

  always_comb begin
    settle = d2_quo + SN'(d2_nz) + SN'(tbecu_pkg::SETTLE_ADD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (t2_out.speed_valid) begin
      out_speed_valid          <= 1'b1;
      out_model_index          <= t2_out.idx;
      out_vel_dmm              <= t2_out.v;
      out_fast_vel_dmm         <= t2_out.vf;
      out_nominal_ticks        <= t2_out.nom_ticks;
      out_fast_ticks           <= t2_out.fast_ticks;
      out_slow_ticks           <= t2_out.slow_ticks;
      out_stop_mm              <= t2_out.stop;
      out_uncertainty_mm       <= t2_out.unc;
      out_braking_mm           <= t2_out.brake;
      out_settle_cnt           <= settle[tbecu_pkg::SETTLE_W-1:0];
      out_watchdog_ticks       <= t2_out.slow ? tbecu_pkg::WD_SLOW : tbecu_pkg::WD_FAST;
    end else begin
      out_speed_valid          <= 1'b0;
      out_model_index          <= '0;
      out_vel_dmm              <= '0;
      out_fast_vel_dmm         <= '0;
      out_nominal_ticks        <= '0;
      out_fast_ticks           <= '0;
      out_slow_ticks           <= '0;
      out_stop_mm              <= '0;
      out_uncertainty_mm       <= '0;
      out_braking_mm           <= '0;
      out_settle_cnt           <= '0;
      out_watchdog_ticks       <= '0;
    end
  end

  assign out_strobe = o_vld_r;

endmodule

// ===== hw/rtl/train_braking_envelope_calculator_unit.sv =====
`timescale 1ns / 1ps

// Braking envelope calculator. Pulse start with a speed and a distance while busy
// is low; one result appears per command, marked by a one-cycle out_strobe, in
// command order. A new command may be given every cycle. Each command passes through
// 48 register stages in all, the first loaded at the accepting edge, set by the two
// bit-serial pipelined dividers in series (28 stages for the travel ticks and curve
// interpolation, 16 stages for the settle ticks) plus the queue slot, two scaling
// stages and the output register. Results cannot be held off, so the receiver must
// take each beat as it comes.

module train_braking_envelope_calculator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tbecu_pkg::SPEED_W-1:0]  in_speed,
  input  logic [tbecu_pkg::DIST_W-1:0]   in_travel_mm,
  output logic                           out_strobe,
  output logic                           out_speed_valid,
  output logic [tbecu_pkg::IDX_W-1:0]    out_model_index,
  output logic [tbecu_pkg::VEL_W-1:0]    out_vel_dmm,
  output logic [tbecu_pkg::VEL_W-1:0]    out_fast_vel_dmm,
  output logic [tbecu_pkg::TICK_W-1:0]   out_nominal_ticks,
  output logic [tbecu_pkg::TICK_W-1:0]   out_fast_ticks,
  output logic [tbecu_pkg::TICK_W-1:0]   out_slow_ticks,
  output logic [tbecu_pkg::STOP_W-1:0]   out_stop_mm,
  output logic [tbecu_pkg::UNC_W-1:0]    out_uncertainty_mm,
  output logic [tbecu_pkg::BRAKE_W-1:0]  out_braking_mm,
  output logic [tbecu_pkg::SETTLE_W-1:0] out_settle_cnt,
  output logic [tbecu_pkg::WD_W-1:0]     out_watchdog_ticks
);

  tbecu_pkg::item_t f_item, q_item;
  logic             q_full, q_vld, push;

  assign busy = q_full;
  assign push = start && !q_full;

  tbecu_front u_front (
    .speed     (in_speed),
    .travel_mm (in_travel_mm),
    .item      (f_item)
  );

  tbecu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop_vld   (q_vld),
    .pop_item  (q_item)
  );

  tbecu_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_vld                   (q_vld),
    .item                     (q_item),
    .out_strobe               (out_strobe),
    .out_speed_valid          (out_speed_valid),
    .out_model_index          (out_model_index),
    .out_vel_dmm              (out_vel_dmm),
    .out_fast_vel_dmm         (out_fast_vel_dmm),
    .out_nominal_ticks        (out_nominal_ticks),
    .out_fast_ticks           (out_fast_ticks),
    .out_slow_ticks           (out_slow_ticks),
    .out_stop_mm              (out_stop_mm),
    .out_uncertainty_mm       (out_uncertainty_mm),
    .out_braking_mm           (out_braking_mm),
    .out_settle_cnt           (out_settle_cnt),
    .out_watchdog_ticks       (out_watchdog_ticks)
  );

endmodule

// ===== bench/tb_train_braking_envelope_calculator_unit.sv =====
`timescale 1ns / 1ps

module tb_train_braking_envelope_calculator_unit;

  localparam int SPW = tbecu_pkg::SPEED_W;
  localparam int DSW = tbecu_pkg::DIST_W;

  typedef struct {
    logic                           speed_valid;
    logic [tbecu_pkg::IDX_W-1:0]    model_index;
    logic [tbecu_pkg::VEL_W-1:0]    vel_dmm;
    logic [tbecu_pkg::VEL_W-1:0]    fast_vel_dmm;
    logic [tbecu_pkg::TICK_W-1:0]   nominal_ticks;
    logic [tbecu_pkg::TICK_W-1:0]   fast_ticks;
    logic [tbecu_pkg::TICK_W-1:0]   slow_ticks;
    logic [tbecu_pkg::STOP_W-1:0]   stop_mm;
    logic [tbecu_pkg::UNC_W-1:0]    uncertainty_mm;
    logic [tbecu_pkg::BRAKE_W-1:0]  braking_mm;
    logic [tbecu_pkg::SETTLE_W-1:0] settle_cnt;
    logic [tbecu_pkg::WD_W-1:0]     watchdog_ticks;
  } envelope_t;

  class envelope_board;
    envelope_t pending[$];
    int errors;

    static function longint unsigned ceil_quot(longint unsigned n, longint unsigned d);
      if (d == 0) return 0;
      return n / d + ((n % d) != 0);
    endfunction

    static function longint unsigned curve_um(int unsigned spd, bit flr);
      int unsigned kn[9];
      int unsigned um[9];
      int unsigned up;
      if (flr) begin
        kn = '{0, 14, 20, 30, 40, 60, 80, 100, 120};
        um = '{0, 38100, 50800, 63500, 127000, 342900, 812800, 1168400, 1524000};
      end else begin
        kn = '{0, 20, 40, 60, 70, 80, 90, 100, 120};
        um = '{0, 50000, 110000, 240000, 390000, 530000, 740000, 875000, 1435000};
      end
      up = 1;
      while (up < 8 && spd > kn[up]) up++;
      return um[up-1] + ceil_quot(longint'(um[up] - um[up-1]) * (spd - kn[up-1]),
                                  kn[up] - kn[up-1]);
    endfunction

    function void note_command(logic [tbecu_pkg::SPEED_W-1:0] spd,
                               logic [tbecu_pkg::DIST_W-1:0] trip);
      envelope_t e;
      int unsigned vel[15] = '{0, 12, 18, 24, 31, 38, 45, 52, 59, 66, 73, 80, 87, 94, 101};
      longint unsigned idx, v, vf, vs, stp, unc, fs, fenv, brk, num;
      longint unsigned nom, fst, slw, stl;
      e = '{default: 0};
      if (spd >= 1 && spd <= tbecu_pkg::SPEED_MAX) begin
        idx = (spd * 14 + 60) / 120;
        if (idx < 1) idx = 1;
        if (idx > 14) idx = 14;
        v = vel[idx];
        vf = v + (v + 4) / 5;
        vs = v / 2;
        if (vs == 0) vs = 1;
        stp = (curve_um(spd, 0) + 999) / 1000;
        unc = stp / 4 > 250 ? stp / 4 : 250;
        fs = (curve_um(spd, 1) + 999) / 1000;
        fenv = fs + (fs / 4 > 250 ? fs / 4 : 250);
        brk = stp + unc > fenv ? stp + unc : fenv;
        num = longint'(trip) * 10;
        nom = ceil_quot(num, v);
        fst = ceil_quot(num, vf);
        slw = ceil_quot(num, vs);
        stl = ceil_quot(brk * 10, vs) + 20;
        e.speed_valid = 1'b1;
        e.model_index = idx[tbecu_pkg::IDX_W-1:0];
        e.vel_dmm = v[tbecu_pkg::VEL_W-1:0];
        e.fast_vel_dmm = vf[tbecu_pkg::VEL_W-1:0];
        e.nominal_ticks = nom[tbecu_pkg::TICK_W-1:0];
        e.fast_ticks = fst[tbecu_pkg::TICK_W-1:0];
        e.slow_ticks = slw[tbecu_pkg::TICK_W-1:0];
        e.stop_mm = stp[tbecu_pkg::STOP_W-1:0];
        e.uncertainty_mm = unc[tbecu_pkg::UNC_W-1:0];
        e.braking_mm = brk[tbecu_pkg::BRAKE_W-1:0];
        e.settle_cnt = stl[tbecu_pkg::SETTLE_W-1:0];
        e.watchdog_ticks = (spd <= tbecu_pkg::SPEED_SLOW) ? tbecu_pkg::WD_SLOW :
                           tbecu_pkg::WD_FAST;
      end
      pending.push_back(e);
    endfunction

    function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(envelope_t a);
      envelope_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("speed_valid", e.speed_valid, a.speed_valid);
      cmp("model_index", e.model_index, a.model_index);
      cmp("vel_dmm", e.vel_dmm, a.vel_dmm);
      cmp("fast_vel_dmm", e.fast_vel_dmm, a.fast_vel_dmm);
      cmp("nominal_ticks", e.nominal_ticks, a.nominal_ticks);
      cmp("fast_ticks", e.fast_ticks, a.fast_ticks);
      cmp("slow_ticks", e.slow_ticks, a.slow_ticks);
      cmp("stop_mm", e.stop_mm, a.stop_mm);
      cmp("uncertainty_mm", e.uncertainty_mm, a.uncertainty_mm);
      cmp("braking_mm", e.braking_mm, a.braking_mm);
      cmp("settle_cnt", e.settle_cnt, a.settle_cnt);
      cmp("watchdog_ticks", e.watchdog_ticks, a.watchdog_ticks);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [SPW-1:0] in_speed = 0;
  logic [DSW-1:0] in_travel_mm = 0;
  logic out_strobe;
  envelope_t act;
  envelope_board board = new();
  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 200000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  train_braking_envelope_calculator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_speed(in_speed), .in_travel_mm(in_travel_mm),
    .out_strobe(out_strobe),
    .out_speed_valid(act.speed_valid),
    .out_model_index(act.model_index),
    .out_vel_dmm(act.vel_dmm),
    .out_fast_vel_dmm(act.fast_vel_dmm),
    .out_nominal_ticks(act.nominal_ticks),
    .out_fast_ticks(act.fast_ticks),
    .out_slow_ticks(act.slow_ticks),
    .out_stop_mm(act.stop_mm),
    .out_uncertainty_mm(act.uncertainty_mm),
    .out_braking_mm(act.braking_mm),
    .out_settle_cnt(act.settle_cnt),
    .out_watchdog_ticks(act.watchdog_ticks)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) board.check_result(act);
    if (rst_n && start && !busy) board.note_command(in_speed, in_travel_mm);
    if (cycles > CYCLE_LIMIT) begin
      $display("[train_braking_envelope_calculator_unit] ERROR");
      $finish;
    end
  end

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_command(logic [SPW-1:0] spd, logic [DSW-1:0] trip, bit gaps);
    if (gaps) idle_gap();
    start <= 1;
    in_speed <= spd;
    in_travel_mm <= trip;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [DSW-1:0] rand_dist();
    case ($urandom_range(0, 4))
      0: return DSW'($urandom_range(0, 1000));
      1: return {DSW{1'b1}} - DSW'($urandom_range(0, 1000));
      default: return DSW'($urandom());
    endcase
  endfunction

  initial begin
    logic [SPW-1:0] dir_spd[] = '{0, 1, 4, 5, 14, 20, 21, 40, 60, 70, 100, 119, 120,
                                  121, 127};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_spd[i]) send_command(dir_spd[i], (i % 2) ? {DSW{1'b1}} : DSW'(i), 1'b0);
    send_command(SPW'(60), DSW'(0), 1'b0);
    send_command(SPW'(127), {DSW{1'b1}}, 1'b0);
    for (int i = 0; i < 1150; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_command(SPW'($urandom_range(0, 127)), rand_dist(), i >= 400);
      else
        send_command(SPW'($urandom_range(1, 120)), rand_dist(), i >= 400);
    end
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0)
      $display("[train_braking_envelope_calculator_unit] OK");
    else
      $display("[train_braking_envelope_calculator_unit] ERROR");
    $finish;
  end
endmodule
